/* rtl/rpt_pkg.sv */
package rpt_pkg;

  localparam int unsigned RPT_INFLIGHT_DEPTH = 256;
  localparam int unsigned IDX_W = 64;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned ACT_W = 4;
  localparam int unsigned MODE_W = 2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    RING_CLEAR      = 2'd0,
    RING_ADD        = 2'd1,
    RING_FREE_TO    = 2'd2,
    RING_FREE_FIRST = 2'd3
  } ring_op_e;

  typedef struct packed {
    logic             start;
    ring_op_e         op;
    logic [IDX_W-1:0] operand;
  } ring_cmd_t;

  typedef struct packed {
    logic             done;
    logic             full;
    logic             overflow;
    logic [CNT_W-1:0] count;
  } ring_sts_t;

endpackage

/* rtl/rpt_ring_mem.sv */
module rpt_ring_mem import rpt_pkg::*; #(
  parameter int unsigned DEPTH  = RPT_INFLIGHT_DEPTH,
  parameter int unsigned ADDR_W = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [IDX_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [IDX_W-1:0] rdata_o
);

  logic [IDX_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rpt_ring_ctrl.sv */
module rpt_ring_ctrl import rpt_pkg::*; #(
  parameter int unsigned INFLIGHT_DEPTH = RPT_INFLIGHT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LIMIT_W-1:0] limit_i,
  input  ring_cmd_t          cmd_i,
  output ring_sts_t          sts_o
);

  localparam int unsigned PTR_W = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
  localparam int unsigned SUM_W = ((PTR_W > LIMIT_W) ? PTR_W : LIMIT_W) + 1;
  localparam int unsigned NRM_W = LIMIT_W + PTR_W;
  localparam int unsigned K_W = (PTR_W > 1) ? $clog2(PTR_W) : 1;

  typedef enum logic [2:0] {
    R_IDLE,
    R_NORM,
    R_RUN,
    R_WALK,
    R_FIRST
  } rstate_e;

  rstate_e          state_q, state_d;
  ring_op_e         op_q, op_d;
  logic [IDX_W-1:0] to_q, to_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [K_W-1:0]   k_q, k_d;
  logic             done_q, done_d;
  logic             ovf_q, ovf_d;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [PTR_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_rdata;

  logic             full;
  logic [SUM_W-1:0] head_inc;
  logic [PTR_W-1:0] head_nxt;
  logic [SUM_W-1:0] slot_sum;
  logic [PTR_W-1:0] slot;
  logic [NRM_W-1:0] nrm_div;
  logic [NRM_W-1:0] nrm_rem;

  assign full = count_q >= CNT_W'(limit_i);

  assign head_inc = SUM_W'(ptr_q) + SUM_W'(1);
  assign head_nxt = (head_inc >= SUM_W'(limit_i)) ? '0 : PTR_W'(head_inc);

  always_comb begin
    slot_sum = SUM_W'(ptr_q) + SUM_W'(count_q);
    if (slot_sum >= SUM_W'(limit_i)) begin
      slot_sum = slot_sum - SUM_W'(limit_i);
    end
    slot = PTR_W'(slot_sum);
  end

  assign nrm_div = NRM_W'(limit_i) << k_q;
  assign nrm_rem = NRM_W'(ptr_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    to_d      = to_q;
    head_d    = head_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    k_d       = k_q;
    done_d    = 1'b0;
    ovf_d     = ovf_q;
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_raddr = ptr_q;
    unique case (state_q)
      R_IDLE: begin
        if (cmd_i.start) begin
          op_d  = cmd_i.op;
          to_d  = cmd_i.operand;
          ovf_d = 1'b0;
          ptr_d = head_q;
          if (cmd_i.op != RING_CLEAR && SUM_W'(head_q) >= SUM_W'(limit_i)) begin
            k_d     = K_W'(PTR_W - 1);
            state_d = R_NORM;
          end else begin
            state_d = R_RUN;
          end
        end
      end
      R_NORM: begin
        if (nrm_rem >= nrm_div) begin
          ptr_d = PTR_W'(nrm_rem - nrm_div);
        end
        if (k_q == '0) begin
          state_d = R_RUN;
        end else begin
          k_d = k_q - K_W'(1);
        end
      end
      R_RUN: begin
        unique case (op_q)
          RING_CLEAR: begin
            head_d  = '0;
            ptr_d   = '0;
            count_d = '0;
            done_d  = 1'b1;
            state_d = R_IDLE;
          end
          RING_ADD: begin
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
            done_d  = 1'b1;
            state_d = R_IDLE;
          end
          RING_FREE_TO: begin
            state_d = R_WALK;
          end
          RING_FREE_FIRST: begin
            state_d = R_FIRST;
          end
          default: begin
            done_d  = 1'b1;
            state_d = R_IDLE;
          end
        endcase
      end
      R_FIRST: begin
        if (count_q == '0) begin
          done_d  = 1'b1;
          state_d = R_IDLE;
        end else begin
          to_d    = mem_rdata;
          state_d = R_WALK;
        end
      end
      R_WALK: begin
        if (count_q != '0 && to_q >= mem_rdata) begin
          head_d    = head_nxt;
          ptr_d     = head_nxt;
          count_d   = count_q - CNT_W'(1);
          mem_raddr = head_nxt;
        end else begin
          done_d  = 1'b1;
          state_d = R_IDLE;
        end
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      op_q    <= RING_CLEAR;
      to_q    <= '0;
      head_q  <= '0;
      ptr_q   <= '0;
      count_q <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      to_q    <= to_d;
      head_q  <= head_d;
      ptr_q   <= ptr_d;
      count_q <= count_d;
      k_q     <= k_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
    end
  end

  rpt_ring_mem #(
    .DEPTH  (INFLIGHT_DEPTH),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (to_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign sts_o.done     = done_q;
  assign sts_o.full     = full;
  assign sts_o.overflow = ovf_q;
  assign sts_o.count    = count_q;

endmodule

/* rtl/replication_progress_tracker_core.sv */
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   action_i, log_index_i, last_index_i
// out       output     out_valid_o / out_stall_i accepted_o ... overflow_error_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_inflight_limit_i
//
// An event without ring work passes through S_EXEC and S_OUT into the output register,
// and the next event is taken once the core is back in S_IDLE; a held output keeps it in S_OUT.
// Ring events also pass through S_RING until the ring is done, and a free walk steps once per freed entry.
// While the ring head lies at or above the limit, each add or free first reduces
// the head in R_NORM, one quotient bit per cycle.
// Reset returns all registers to their reset values at once; the ring memory needs no clearing pass.
// A finished result waits in the output register while the next event is taken in.
module replication_progress_tracker_core import rpt_pkg::*; #(
  parameter int unsigned INFLIGHT_DEPTH = RPT_INFLIGHT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [IDX_W-1:0]   log_index_i,
  input  logic [IDX_W-1:0]   last_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic               is_paused_o,
  output logic               snapshot_abort_o,
  output logic [MODE_W-1:0]  mode_o,
  output logic [IDX_W-1:0]   match_index_o,
  output logic [IDX_W-1:0]   next_index_o,
  output logic [CNT_W-1:0]   inflight_count_o,
  output logic               overflow_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_inflight_limit_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RING,
    S_OUT
  } state_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PROBE     = 2'd0,
    MODE_REPLICATE = 2'd1,
    MODE_SNAPSHOT  = 2'd2
  } mode_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_QUERY      = 4'd0,
    ACT_PROBE      = 4'd1,
    ACT_REPLICATE  = 4'd2,
    ACT_SNAPSHOT   = 4'd3,
    ACT_SNAPFAIL   = 4'd4,
    ACT_UPDATE     = 4'd5,
    ACT_OPTIMISTIC = 4'd6,
    ACT_DECREMENT  = 4'd7,
    ACT_PAUSE      = 4'd8,
    ACT_RESUME     = 4'd9,
    ACT_ADD        = 4'd10,
    ACT_FREE_TO    = 4'd11,
    ACT_FREE_FIRST = 4'd12
  } action_e;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [IDX_W-1:0]   matched_q, matched_d;
  logic [IDX_W-1:0]   next_q, next_d;
  logic               paused_q, paused_d;
  logic [IDX_W-1:0]   pend_q, pend_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [ACT_W-1:0]   act_q, act_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   last_q, last_d;
  logic               acc_q, acc_d;

  logic               out_valid_q, out_valid_d;
  logic               out_acc_q, out_acc_d;
  logic               out_paused_q, out_paused_d;
  logic               out_abort_q, out_abort_d;
  mode_e              out_mode_q, out_mode_d;
  logic [IDX_W-1:0]   out_match_q, out_match_d;
  logic [IDX_W-1:0]   out_next_q, out_next_d;
  logic [CNT_W-1:0]   out_count_q, out_count_d;
  logic               out_ovf_q, out_ovf_d;

  logic [LIMIT_W-1:0] eff_limit;
  ring_cmd_t          ring_cmd;
  ring_sts_t          ring_sts;

  logic [IDX_W-1:0]   matched_inc;
  logic [IDX_W-1:0]   pend_inc;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   last_inc;
  logic [IDX_W-1:0]   next_dec;
  logic [IDX_W-1:0]   dec_val;

  assign matched_inc = matched_q + IDX_W'(1);
  assign pend_inc    = pend_q + IDX_W'(1);
  assign idx_inc     = idx_q + IDX_W'(1);
  assign last_inc    = last_q + IDX_W'(1);
  assign next_dec    = next_q - IDX_W'(1);

  always_comb begin
    dec_val = (idx_q < last_inc) ? idx_q : last_inc;
    if (dec_val == '0) begin
      dec_val = IDX_W'(1);
    end
  end

  always_comb begin
    if (limit_q == '0) begin
      eff_limit = LIMIT_W'(1);
    end else if (32'(limit_q) > INFLIGHT_DEPTH) begin
      eff_limit = LIMIT_W'(INFLIGHT_DEPTH);
    end else begin
      eff_limit = limit_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d          = state_q;
    mode_d           = mode_q;
    matched_d        = matched_q;
    next_d           = next_q;
    paused_d         = paused_q;
    pend_d           = pend_q;
    act_d            = act_q;
    idx_d            = idx_q;
    last_d           = last_q;
    acc_d            = acc_q;
    ring_cmd.start   = 1'b0;
    ring_cmd.op      = RING_CLEAR;
    ring_cmd.operand = idx_q;
    out_valid_d      = out_valid_q & out_stall_i;
    out_acc_d        = out_acc_q;
    out_paused_d     = out_paused_q;
    out_abort_d      = out_abort_q;
    out_mode_d       = out_mode_q;
    out_match_d      = out_match_q;
    out_next_d       = out_next_q;
    out_count_d      = out_count_q;
    out_ovf_d        = out_ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          idx_d   = log_index_i;
          last_d  = last_index_i;
          acc_d   = 1'b0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        unique case (act_q)
          ACT_PROBE: begin
            mode_d         = MODE_PROBE;
            paused_d       = 1'b0;
            pend_d         = '0;
            next_d         = matched_inc;
            if (mode_q == MODE_SNAPSHOT && pend_inc > matched_inc) begin
              next_d = pend_inc;
            end
            ring_cmd.start = 1'b1;
            state_d        = S_RING;
          end
          ACT_REPLICATE: begin
            mode_d         = MODE_REPLICATE;
            paused_d       = 1'b0;
            pend_d         = '0;
            next_d         = matched_inc;
            ring_cmd.start = 1'b1;
            state_d        = S_RING;
          end
          ACT_SNAPSHOT: begin
            mode_d         = MODE_SNAPSHOT;
            paused_d       = 1'b0;
            pend_d         = idx_q;
            ring_cmd.start = 1'b1;
            state_d        = S_RING;
          end
          ACT_SNAPFAIL: begin
            pend_d = '0;
          end
          ACT_UPDATE: begin
            if (matched_q < idx_q) begin
              matched_d = idx_q;
              paused_d  = 1'b0;
              acc_d     = 1'b1;
            end
            if (next_q < idx_inc) begin
              next_d = idx_inc;
            end
          end
          ACT_OPTIMISTIC: begin
            next_d = idx_inc;
          end
          ACT_DECREMENT: begin
            if (mode_q == MODE_REPLICATE) begin
              if (idx_q >= matched_q) begin
                next_d = matched_inc;
                acc_d  = 1'b1;
              end
            end else if (next_q != '0 && next_dec == idx_q) begin
              next_d   = dec_val;
              paused_d = 1'b0;
              acc_d    = 1'b1;
            end
          end
          ACT_PAUSE: begin
            paused_d = 1'b1;
          end
          ACT_RESUME: begin
            paused_d = 1'b0;
          end
          ACT_ADD: begin
            ring_cmd.start = 1'b1;
            ring_cmd.op    = RING_ADD;
            state_d        = S_RING;
          end
          ACT_FREE_TO: begin
            ring_cmd.start = 1'b1;
            ring_cmd.op    = RING_FREE_TO;
            state_d        = S_RING;
          end
          ACT_FREE_FIRST: begin
            ring_cmd.start = 1'b1;
            ring_cmd.op    = RING_FREE_FIRST;
            state_d        = S_RING;
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_RING: begin
        if (ring_sts.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          unique case (mode_q)
            MODE_PROBE:     out_paused_d = paused_q;
            MODE_REPLICATE: out_paused_d = ring_sts.full;
            default:        out_paused_d = 1'b1;
          endcase
          out_abort_d = (mode_q == MODE_SNAPSHOT) && (matched_q >= pend_q);
          out_mode_d  = mode_q;
          out_match_d = matched_q;
          out_next_d  = next_q;
          out_count_d = ring_sts.count;
          out_ovf_d   = (act_q == ACT_ADD) && ring_sts.overflow;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_PROBE;
      matched_q    <= '0;
      next_q       <= IDX_W'(1);
      paused_q     <= 1'b0;
      pend_q       <= '0;
      limit_q      <= LIMIT_RESET;
      act_q        <= ACT_QUERY;
      idx_q        <= '0;
      last_q       <= '0;
      acc_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_acc_q    <= 1'b0;
      out_paused_q <= 1'b0;
      out_abort_q  <= 1'b0;
      out_mode_q   <= MODE_PROBE;
      out_match_q  <= '0;
      out_next_q   <= '0;
      out_count_q  <= '0;
      out_ovf_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      matched_q    <= matched_d;
      next_q       <= next_d;
      paused_q     <= paused_d;
      pend_q       <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_inflight_limit_i;
      end
      act_q        <= act_d;
      idx_q        <= idx_d;
      last_q       <= last_d;
      acc_q        <= acc_d;
      out_valid_q  <= out_valid_d;
      out_acc_q    <= out_acc_d;
      out_paused_q <= out_paused_d;
      out_abort_q  <= out_abort_d;
      out_mode_q   <= out_mode_d;
      out_match_q  <= out_match_d;
      out_next_q   <= out_next_d;
      out_count_q  <= out_count_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

  rpt_ring_ctrl #(
    .INFLIGHT_DEPTH (INFLIGHT_DEPTH)
  ) u_ring_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .limit_i (eff_limit),
    .cmd_i   (ring_cmd),
    .sts_o   (ring_sts)
  );

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_acc_q;
  assign is_paused_o      = out_paused_q;
  assign snapshot_abort_o = out_abort_q;
  assign mode_o           = out_mode_q;
  assign match_index_o    = out_match_q;
  assign next_index_o     = out_next_q;
  assign inflight_count_o = out_count_q;
  assign overflow_error_o = out_ovf_q;

endmodule
